@@ rtl/core/srws_pkg.sv @@
// shared types, constants and codes for the sprite row warp scaler
package srws_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int ADDR_W     = ROW_W + COL_W;
    localparam int SHAPE_ROWS = 64;
    localparam int SHAPE_AW   = 6;
    localparam int CFG_W      = 7;
    localparam int PIX_W      = 32;
    localparam int FRAC_W     = 8;
    localparam int QUO_W      = CFG_W + FRAC_W;
    localparam int DIVR_W     = 8;
    localparam int CNT_W      = 4;
    localparam int SHAPE_W    = 15;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    localparam logic [7:0] DP_MAX = 8'd255;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;
    localparam logic [CFG_W-1:0] ROW_LIMIT = 7'd64;

    // item modes
    localparam logic [1:0] MODE_PIXEL  = 2'd0;
    localparam logic [1:0] MODE_SHAPE  = 2'd1;
    localparam logic [1:0] MODE_RENDER = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_SRC_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_SRC_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_OUT_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_OUT_HEIGHT = 2'd3;

    typedef struct packed {
        logic [1:0]        mode;
        logic [5:0]        row;
        logic [5:0]        col;
        logic [31:0]       pixel_in;
        logic [6:0]        outer_offset;
        logic signed [7:0] inner_offset;
        logic [7:0]        frame;
    } in_item_t;

    typedef struct packed {
        logic [31:0] pixel_out;
        logic [5:0]  out_col;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic              start;
        logic [QUO_W-1:0]  dividend;
        logic [DIVR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALCY,
        ST_CALCX,
        ST_CHECK,
        ST_DIVY,
        ST_SROW,
        ST_DIVX,
        ST_EMIT
    } state_t;

endpackage

@@ rtl/core/srws_div.sv @@
// radix-2 restoring divider, one quotient bit per cycle
module srws_div
    import srws_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [QUO_W-1:0]  quo_next;
    logic [DIVR_W-1:0] rem_reg;
    logic [DIVR_W-1:0] rem_next;
    logic [DIVR_W-1:0] dvs_reg;
    logic [DIVR_W:0]   trial;

    // one shift-subtract step
    always_comb
    begin
        trial = {rem_reg, quo_reg[QUO_W-1]};
        if (trial >= {1'b0, dvs_reg})
        begin
            rem_next = DIVR_W'(trial - {1'b0, dvs_reg});
            quo_next = {quo_reg[QUO_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial[DIVR_W-1:0];
            quo_next = {quo_reg[QUO_W-2:0], 1'b0};
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(QUO_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

@@ rtl/core/srws_store.sv @@
// source pixel memory and shape pair memory, with registered read data
module srws_store
    import srws_pkg::*;
(
    input  logic               clk,
    input  logic               src_we,
    input  logic [ADDR_W-1:0]  src_waddr,
    input  logic [PIX_W-1:0]   src_wdata,
    input  logic               src_re,
    input  logic [ADDR_W-1:0]  src_raddr,
    output logic [PIX_W-1:0]   src_rdata,
    input  logic               shp_we,
    input  logic [SHAPE_AW-1:0] shp_waddr,
    input  logic [SHAPE_W-1:0] shp_wdata,
    input  logic               shp_re,
    input  logic [SHAPE_AW-1:0] shp_raddr,
    output logic [SHAPE_W-1:0] shp_rdata
);

    logic [PIX_W-1:0]   src_mem [MAX_WIDTH*MAX_HEIGHT];
    logic [SHAPE_W-1:0] shp_mem [SHAPE_ROWS];
    logic [PIX_W-1:0]   src_rdata_reg;
    logic [SHAPE_W-1:0] shp_rdata_reg;

    // source pixel memory
    always_ff @(posedge clk)
    begin
        if (src_we)
        begin
            src_mem[src_waddr] <= src_wdata;
        end
        if (src_re)
        begin
            src_rdata_reg <= src_mem[src_raddr];
        end
    end

    // shape pair memory
    always_ff @(posedge clk)
    begin
        if (shp_we)
        begin
            shp_mem[shp_waddr] <= shp_wdata;
        end
        if (shp_re)
        begin
            shp_rdata_reg <= shp_mem[shp_raddr];
        end
    end

    assign src_rdata = src_rdata_reg;
    assign shp_rdata = shp_rdata_reg;

endmodule

@@ rtl/core/srws_fifo.sv @@
// small output queue decoupling the pixel read pipe from the result channel
module srws_fifo
    import srws_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  out_item_t          push_data,
    output logic [FIFO_CW-1:0] count,
    output logic               out_valid,
    input  logic               out_stall,
    output out_item_t          out_data
);

    out_item_t           mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  wr_ptr_reg;
    logic [FIFO_AW-1:0]  rd_ptr_reg;
    logic [FIFO_CW-1:0]  cnt_reg;
    logic                pop;

    assign pop       = out_valid & ~out_stall;
    assign out_valid = (cnt_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign count     = cnt_reg;

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/core/sprite_row_warp_scaler_top.sv @@
// sprite row warp scaler: load sequencing, row setup and pixel emission
// load items (pixel or shape pair) are written when accepted and produce no transfer.
// a render item runs setup after its transfer (three setup steps, a source row step
// and two divisions in the shared divider), only the three setup steps if the row
// is not covered, then issues one read per cycle while the queue has room,
// n = min(out_width, 64) reads, each through the read register and the queue.
// one item at a time; the next item is accepted in the cycle after the last read.
// reset: configuration registers to 64, queue empty; memories are not cleared.
module sprite_row_warp_scaler_top
    import srws_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output out_item_t        out_data,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    state_t state_reg;
    state_t state_next;

    logic [CFG_W-1:0] src_width_reg;
    logic [CFG_W-1:0] src_height_reg;
    logic [CFG_W-1:0] out_width_reg;
    logic [CFG_W-1:0] out_height_reg;

    logic              accept;
    logic [CFG_W-1:0]  n_cols;
    logic [7:0]        dp_in;

    logic [7:0]        f_reg;
    logic [7:0]        dp_reg;
    logic [5:0]        r_reg;
    logic [6:0]        y1_reg;
    logic signed [8:0] y2_reg;
    logic [6:0]        x1_reg;
    logic signed [8:0] x2_reg;
    logic signed [10:0] yr_reg;
    logic signed [10:0] xr_reg;
    logic [5:0]        ry_reg;
    logic              covered_reg;
    logic [5:0]        srow_reg;
    logic              srow_ok_reg;
    logic [5:0]        col_reg;

    logic              infl_valid_reg;
    logic              infl_zero_reg;
    logic [5:0]        infl_col_reg;
    logic              infl_last_reg;

    logic [14:0]       prod_y1;
    logic signed [7:0] dsh;
    logic signed [16:0] prod_y2;
    logic [6:0]        shp_outer;
    logic signed [7:0] shp_inner;
    logic [14:0]       prod_x1;
    logic signed [16:0] prod_x2;
    logic signed [10:0] yr_calc;
    logic signed [10:0] xr_calc;
    logic signed [10:0] ry_diff;
    logic              row_ok;
    logic              go_cover;
    logic [20:0]       prod_srow;

    logic [7:0]        jd;
    logic [5:0]        jcol;
    logic              col_cov;
    logic [20:0]       prod_sc;
    logic              pix_ok;
    logic              last_col;
    logic              credit;
    logic              issue;

    div_req_t          div_req;
    div_rsp_t          div_rsp;

    logic [PIX_W-1:0]   src_rdata;
    logic [SHAPE_W-1:0] shp_rdata;
    logic [FIFO_CW-1:0] fifo_count;
    out_item_t          push_data;

    // input transfer and row length
    assign accept = in_valid & ~in_stall;
    assign n_cols = (out_width_reg > ROW_LIMIT) ? ROW_LIMIT : out_width_reg;
    assign dp_in  = in_data.frame[7] ? DP_MAX : {in_data.frame[6:0], 1'b0};

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= CFG_RESET;
            src_height_reg <= CFG_RESET;
            out_width_reg  <= CFG_RESET;
            out_height_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SRC_WIDTH:  src_width_reg  <= cfg_data;
                CFG_SRC_HEIGHT: src_height_reg <= cfg_data;
                CFG_OUT_WIDTH:  out_width_reg  <= cfg_data;
                CFG_OUT_HEIGHT: out_height_reg <= cfg_data;
                default:        src_width_reg  <= src_width_reg;
            endcase
        end
    end

    // vertical span products
    assign prod_y1 = out_height_reg * f_reg;
    assign dsh     = $signed({1'b0, out_height_reg}) - $signed({1'b0, src_height_reg});
    assign prod_y2 = dsh * $signed({1'b0, dp_reg});

    // horizontal span products from the shape pair
    assign shp_outer = shp_rdata[14:8];
    assign shp_inner = $signed(shp_rdata[7:0]);
    assign prod_x1   = shp_outer * dp_reg;
    assign prod_x2   = shp_inner * $signed({1'b0, dp_reg});

    // span lengths and row coverage
    assign yr_calc = $signed({{2{y2_reg[8]}}, y2_reg}) - $signed({4'b0, y1_reg})
                   + $signed({4'b0, src_height_reg});
    assign xr_calc = $signed({{2{x2_reg[8]}}, x2_reg}) - $signed({4'b0, x1_reg})
                   + $signed({4'b0, src_width_reg});
    assign ry_diff = $signed({5'b0, r_reg}) - $signed({4'b0, y1_reg});
    assign row_ok  = ({1'b0, r_reg} < out_height_reg) && (yr_reg > 0)
                   && ({1'b0, r_reg} >= y1_reg) && (ry_diff < yr_reg);
    assign go_cover  = row_ok && (xr_calc > 0);
    assign prod_srow = ry_reg * div_rsp.quotient;

    // per-column source coordinate
    assign jd       = {2'b0, col_reg} - {1'b0, x1_reg};
    assign jcol     = jd[5:0];
    assign col_cov  = covered_reg && ({1'b0, col_reg} >= x1_reg)
                    && ($signed({5'b0, jcol}) < xr_reg);
    assign prod_sc  = jcol * div_rsp.quotient;
    assign pix_ok   = col_cov && srow_ok_reg && (prod_sc[20:14] == '0);
    assign last_col = ({1'b0, col_reg} == CFG_W'(n_cols - 1'b1));
    assign credit   = (FIFO_CW'(fifo_count + FIFO_CW'(infl_valid_reg)) < FIFO_CW'(FIFO_DEPTH));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_data.mode == MODE_RENDER && n_cols != '0)
                begin
                    state_next = ST_CALCY;
                end
            end
            ST_CALCY: state_next = ST_CALCX;
            ST_CALCX: state_next = ST_CHECK;
            ST_CHECK: state_next = go_cover ? ST_DIVY : ST_EMIT;
            ST_DIVY:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_SROW;
                end
            end
            ST_SROW:  state_next = ST_DIVX;
            ST_DIVX:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (issue && last_col)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        in_stall         = 1'b1;
        issue            = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = {src_height_reg, 8'b0};
        div_req.divisor  = yr_reg[DIVR_W-1:0];
        case (state_reg)
            ST_IDLE:  in_stall = 1'b0;
            ST_CHECK: div_req.start = go_cover;
            ST_SROW:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {src_width_reg, 8'b0};
                div_req.divisor  = xr_reg[DIVR_W-1:0];
            end
            ST_EMIT:  issue = credit;
            default:  in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            infl_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            infl_valid_reg <= issue;
        end
    end

    // row setup datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                f_reg   <= in_data.frame;
                dp_reg  <= dp_in;
                r_reg   <= in_data.row;
                col_reg <= '0;
            end
            ST_CALCY:
            begin
                y1_reg <= prod_y1[14:8];
                y2_reg <= prod_y2[16:8];
            end
            ST_CALCX:
            begin
                x1_reg <= prod_x1[14:8];
                x2_reg <= prod_x2[16:8];
                yr_reg <= yr_calc;
            end
            ST_CHECK:
            begin
                xr_reg      <= xr_calc;
                ry_reg      <= ry_diff[5:0];
                covered_reg <= go_cover;
            end
            ST_SROW:
            begin
                srow_reg    <= prod_srow[13:8];
                srow_ok_reg <= (prod_srow[20:14] == '0);
            end
            ST_EMIT:
            begin
                if (issue)
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
            default:
            begin
                f_reg <= f_reg;
            end
        endcase
    end

    // read pipe tag for the pixel in flight
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            infl_zero_reg <= ~pix_ok;
            infl_col_reg  <= col_reg;
            infl_last_reg <= last_col;
        end
    end

    assign push_data.pixel_out = infl_zero_reg ? '0 : src_rdata;
    assign push_data.out_col   = infl_col_reg;
    assign push_data.last      = infl_last_reg;

    srws_store u_store (
        .clk       (clk),
        .src_we    (accept && in_data.mode == MODE_PIXEL),
        .src_waddr ({in_data.row, in_data.col}),
        .src_wdata (in_data.pixel_in),
        .src_re    (issue),
        .src_raddr ({srow_reg, prod_sc[13:8]}),
        .src_rdata (src_rdata),
        .shp_we    (accept && in_data.mode == MODE_SHAPE),
        .shp_waddr (in_data.row),
        .shp_wdata ({in_data.outer_offset, in_data.inner_offset}),
        .shp_re    (accept && in_data.mode == MODE_RENDER),
        .shp_raddr (in_data.row),
        .shp_rdata (shp_rdata)
    );

    srws_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    srws_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (infl_valid_reg),
        .push_data (push_data),
        .count     (fifo_count),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
